### hdl/qat_pkg.sv
// qat_pkg: shared types and constants for the quote-aware tokenizer
// no dependencies; imported by every module of the block but qat_ram
package qat_pkg;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int ARG_W = 6;

	typedef enum logic [1:0] {
		REG_MIN_ARGS  = 2'd0,
		REG_MAX_ARGS  = 2'd1,
		REG_FREETEXT  = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ITEM_TOKEN_BYTE = 2'd0,
		ITEM_TOKEN_END  = 2'd1,
		ITEM_STATUS     = 2'd2
	} item_type_t;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_TOO_FEW   = 3'd1,
		ERR_TOO_MANY  = 3'd2,
		ERR_WS_OVF    = 3'd3,
		ERR_TOKEN_OVF = 3'd4
	} error_code_t;

	// settings that the back end reads
	typedef struct packed {
		logic [ARG_W-1:0] min_args;
		logic [ARG_W-1:0] max_args;
		logic             freetext;
	} cfg_t;

	// command from front to back
	typedef struct packed {
		logic       is_eol;
		logic [7:0] data;
		logic       final_cmd;
		logic       ws_ovf;
	} cmd_t;

	// one result item without its last mark
	typedef struct packed {
		item_type_t        item_type;
		logic [7:0]        token_byte;
		logic [6:0]        token_index;
		logic signed [7:0] arg_total;
		logic              line_valid;
		error_code_t       error_code;
	} res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

### hdl/quoted_argument_tokenizer_unit.sv
// quoted_argument_tokenizer_unit: quote-aware command line tokenizer, top level
// a byte with no held whitespace goes through the queue, a step into the result hold and a
// last-mark release into the output register; an end of line closing a token takes an extra
// step first; each held whitespace byte is replayed by a store read and a queue push
// reset: arst_n clears all control state and loads min_args 0, max_args 8, freetext off
// depends on qat_pkg, qat_front, qat_fifo, qat_back
module quoted_argument_tokenizer_unit #(
	parameter int PENDING_DEPTH = 32,
	parameter int TOKEN_LIMIT   = 127
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [5:0]        cfg_wdata,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [7:0]        data_byte,
	// output channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        item_type,
	output logic [7:0]        token_byte,
	output logic [6:0]        token_index,
	output logic signed [7:0] arg_total,
	output logic              line_valid,
	output logic [2:0]        error_code,
	output logic              last
);
	import qat_pkg::*;

	localparam int QUEUE_DEPTH = 4;

	cfg_t cfg_q;
	logic q_push, q_full, q_pop, q_not_empty;
	cmd_t q_in, q_head;
	res_t res;

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_args <= ARG_W'(0);
			cfg_q.max_args <= ARG_W'(8);
			cfg_q.freetext <= 1'b0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MIN_ARGS: cfg_q.min_args <= cfg_wdata;
				REG_MAX_ARGS: cfg_q.max_args <= cfg_wdata;
				REG_FREETEXT: cfg_q.freetext <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// front end: leading whitespace drop, trailing whitespace store and replay
	qat_front #(.PENDING_DEPTH(PENDING_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (q_push),
		.push_cmd  (q_in)
	);

	// short queue so front replay and back output stalls decouple
	qat_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_cmd  (q_head)
	);

	// back end: token state, status check, last-mark hold and output register
	qat_back #(.TOKEN_LIMIT(TOKEN_LIMIT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_not_empty),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res),
		.out_last  (last)
	);

	assign item_type   = res.item_type;
	assign token_byte  = res.token_byte;
	assign token_index = res.token_index;
	assign arg_total   = res.arg_total;
	assign line_valid  = res.line_valid;
	assign error_code  = res.error_code;
endmodule

### hdl/qat_ram.sv
// qat_ram: generic single-write, single-read ram with registered read data
// no dependencies
module qat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### hdl/qat_fifo.sv
// qat_fifo: short command queue between front and back
// depends on qat_pkg for cmd_t
module qat_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qat_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output qat_pkg::cmd_t head_cmd
);
	import qat_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### hdl/qat_front.sv
// qat_front: takes input items, holds trailing whitespace, replays it as commands
// depends on qat_pkg and qat_ram
module qat_front #(
	parameter int PENDING_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          kind,
	input  logic [7:0]    data_byte,
	input  logic          q_full,
	output logic          push,
	output qat_pkg::cmd_t push_cmd
);
	import qat_pkg::*;

	localparam int AW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CNW = $clog2(PENDING_DEPTH + 1);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_RD   = 4'b0010,
		F_PUSH = 4'b0100,
		F_TAIL = 4'b1000
	} fstate_t;

	fstate_t        state_q, state_n;
	logic           line_started_q, line_started_n;
	logic           ws_ovf_q, ws_ovf_n;
	logic [CNW-1:0] count_q, count_n;
	logic [AW-1:0]  rd_idx_q, rd_idx_n;
	logic [7:0]     byte_q, byte_n;
	logic           ram_we, ram_re;
	logic [7:0]     ram_rdata;
	logic           accept;

	qat_ram #(.WIDTH(8), .DEPTH(PENDING_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (data_byte),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == F_IDLE) && !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_n        = state_q;
		line_started_n = line_started_q;
		ws_ovf_n       = ws_ovf_q;
		count_n        = count_q;
		rd_idx_n       = rd_idx_q;
		byte_n         = byte_q;
		ram_we         = 1'b0;
		ram_re         = 1'b0;
		push           = 1'b0;
		push_cmd       = '0;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (kind) begin
						push               = 1'b1;
						push_cmd.is_eol    = 1'b1;
						push_cmd.final_cmd = 1'b1;
						push_cmd.ws_ovf    = ws_ovf_q;
						line_started_n     = 1'b0;
						ws_ovf_n           = 1'b0;
						count_n            = '0;
					end else if (is_ws(data_byte)) begin
						if (line_started_q) begin
							if (count_q < CNW'(PENDING_DEPTH)) begin
								ram_we  = 1'b1;
								count_n = count_q + 1'b1;
							end else begin
								ws_ovf_n = 1'b1;
							end
						end
					end else begin
						line_started_n = 1'b1;
						if (count_q == '0) begin
							push               = 1'b1;
							push_cmd.data      = data_byte;
							push_cmd.final_cmd = 1'b1;
						end else begin
							byte_n   = data_byte;
							rd_idx_n = '0;
							state_n  = F_RD;
						end
					end
				end
			end
			F_RD: begin
				ram_re  = 1'b1;
				state_n = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) begin
					push          = 1'b1;
					push_cmd.data = ram_rdata;
					if (CNW'(rd_idx_q) == count_q - 1'b1) begin
						state_n = F_TAIL;
					end else begin
						rd_idx_n = rd_idx_q + 1'b1;
						state_n  = F_RD;
					end
				end
			end
			F_TAIL: begin
				if (!q_full) begin
					push               = 1'b1;
					push_cmd.data      = byte_q;
					push_cmd.final_cmd = 1'b1;
					count_n            = '0;
					state_n            = F_IDLE;
				end
			end
			default: begin
				state_n = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		byte_q   <= byte_n;
		rd_idx_q <= rd_idx_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= F_IDLE;
			line_started_q <= 1'b0;
			ws_ovf_q       <= 1'b0;
			count_q        <= '0;
		end else begin
			state_q        <= state_n;
			line_started_q <= line_started_n;
			ws_ovf_q       <= ws_ovf_n;
			count_q        <= count_n;
		end
	end
endmodule

### hdl/qat_back.sv
// qat_back: tokenizer, one command step per cycle unless stalled, result hold and output register
// depends on qat_pkg
module qat_back #(
	parameter int TOKEN_LIMIT = 127
) (
	input  logic           clk,
	input  logic           arst_n,
	input  qat_pkg::cfg_t  cfg,
	input  logic           cmd_valid,
	input  qat_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output qat_pkg::res_t  out_res,
	output logic           out_last
);
	import qat_pkg::*;

	localparam int CW   = $clog2(TOKEN_LIMIT + 1);
	localparam int CMPW = ((CW > ARG_W) ? CW : ARG_W) + 2;

	logic          in_tok_q, in_quote_q, in_free_q, take_q, tov_q;
	logic          in_tok_n, in_quote_n, in_free_n, take_n, tov_n;
	logic [CW-1:0] cnt_q, cnt_n;
	res_t          hold_q, out_q;
	logic          hold_v_q, hold_done_q, out_v_q, last_q;

	// result of one step
	logic          r_v;
	res_t          r;
	logic          consume, fin;
	logic          out_free;

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign out_last  = last_q;
	assign out_free  = !out_v_q || out_ready;

	always_comb begin
		logic [7:0]      c;
		logic [CMPW-1:0] cnt_x, min_x, max_x;
		logic [7:0]      cnt8;
		error_code_t     err;
		logic            do_put, do_end;

		c          = cmd.data;
		cnt_x      = CMPW'(cnt_q);
		min_x      = CMPW'(cfg.min_args);
		max_x      = CMPW'(cfg.max_args);
		cnt8       = 8'(cnt_q);
		in_tok_n   = in_tok_q;
		in_quote_n = in_quote_q;
		in_free_n  = in_free_q;
		take_n     = take_q;
		tov_n      = tov_q;
		cnt_n      = cnt_q;
		r_v        = 1'b0;
		r          = '0;
		consume    = 1'b1;
		fin        = cmd.final_cmd;
		do_put     = 1'b0;
		do_end     = 1'b0;
		err        = ERR_OK;

		if (cmd.is_eol) begin
			if (in_tok_q) begin
				// close the open token first, status follows next step
				do_end  = 1'b1;
				consume = 1'b0;
				fin     = 1'b0;
			end else begin
				if (cmd.ws_ovf) begin
					err = ERR_WS_OVF;
				end else if (tov_q) begin
					err = ERR_TOKEN_OVF;
				end else if (cnt_x <= min_x) begin
					err = ERR_TOO_FEW;
				end else if (cnt_x > max_x + 1'b1) begin
					err = ERR_TOO_MANY;
				end
				r_v          = 1'b1;
				r.item_type  = ITEM_STATUS;
				r.arg_total  = cnt8 - 8'd1;
				r.line_valid = (err == ERR_OK);
				r.error_code = err;
				in_quote_n   = 1'b0;
				in_free_n    = 1'b0;
				take_n       = 1'b0;
				tov_n        = 1'b0;
				cnt_n        = '0;
			end
		end else if (take_q) begin
			take_n = 1'b0;
			do_put = 1'b1;
		end else if (!in_tok_q) begin
			if (c != CH_SPACE) begin
				if (cnt_x >= CMPW'(TOKEN_LIMIT)) begin
					tov_n = 1'b1;
				end
				in_tok_n = 1'b1;
				if (cfg.freetext && cnt_x == max_x && c != CH_QUOTE) begin
					in_free_n = 1'b1;
					do_put    = 1'b1;
				end else if (c == CH_QUOTE) begin
					in_quote_n = 1'b1;
					take_n     = 1'b1;
				end else begin
					do_put = 1'b1;
				end
			end
		end else if (in_quote_q) begin
			if (c == CH_QUOTE) begin
				do_end = 1'b1;
			end else begin
				do_put = 1'b1;
			end
		end else if (in_free_q) begin
			do_put = 1'b1;
		end else if (c == CH_SPACE) begin
			do_end = 1'b1;
		end else if (!(cfg.freetext && c == CH_QUOTE)) begin
			do_put = 1'b1;
		end

		if (do_put && !tov_n) begin
			r_v           = 1'b1;
			r.item_type   = ITEM_TOKEN_BYTE;
			r.token_byte  = c;
			r.token_index = 7'(cnt_q);
		end
		if (do_end) begin
			if (!tov_q) begin
				r_v           = 1'b1;
				r.item_type   = ITEM_TOKEN_END;
				r.token_index = 7'(cnt_q);
				cnt_n         = cnt_q + 1'b1;
			end
			in_tok_n   = 1'b0;
			in_quote_n = 1'b0;
			in_free_n  = 1'b0;
		end
	end

	// step runs when a command waits, no flush is due, and it need not push the held result into a busy output
	logic step_ok, flush, step;
	assign flush   = hold_v_q && hold_done_q;
	assign step_ok = !(r_v && hold_v_q) || out_free;
	assign step    = !flush && cmd_valid && step_ok;
	assign cmd_pop = step && consume;

	always_ff @(posedge clk) begin
		if (flush && out_free) begin
			out_q  <= hold_q;
			last_q <= 1'b1;
		end else if (step && r_v && hold_v_q) begin
			out_q  <= hold_q;
			last_q <= 1'b0;
		end
		if (step && r_v) begin
			hold_q <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tok_q    <= 1'b0;
			in_quote_q  <= 1'b0;
			in_free_q   <= 1'b0;
			take_q      <= 1'b0;
			tov_q       <= 1'b0;
			cnt_q       <= '0;
			hold_v_q    <= 1'b0;
			hold_done_q <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			if (flush) begin
				if (out_free) begin
					out_v_q     <= 1'b1;
					hold_v_q    <= 1'b0;
					hold_done_q <= 1'b0;
				end
			end else if (step) begin
				in_tok_q   <= in_tok_n;
				in_quote_q <= in_quote_n;
				in_free_q  <= in_free_n;
				take_q     <= take_n;
				tov_q      <= tov_n;
				cnt_q      <= cnt_n;
				if (r_v && hold_v_q) begin
					out_v_q <= 1'b1;
				end
				hold_v_q    <= hold_v_q || r_v;
				hold_done_q <= fin && (hold_v_q || r_v);
			end
		end
	end
endmodule

### verif/tok_sb_pkg.sv
`timescale 1ns / 100ps
// tok_sb_pkg: result record and scoreboard class for the tokenizer testbench
// depends on qat_pkg for item types, error codes, register indexes and characters
package tok_sb_pkg;
	import qat_pkg::*;

	localparam int HELD_WS_DEPTH = 32;
	localparam int TOKEN_CAP     = 127;

	typedef struct {
		item_type_t        typ;
		logic [7:0]        tbyte;
		logic [6:0]        tindex;
		logic signed [7:0] argc;
		logic              valid_bit;
		error_code_t       code;
		logic              lst;
	} token_result_t;

	class token_scoreboard;
		logic [5:0]    min_args;
		logic [5:0]    max_args;
		logic          freetext;
		bit            started;
		bit            in_tok;
		bit            in_quote;
		bit            in_free;
		bit            take_next;
		int            tok_cnt;
		logic [7:0]    held_ws[$];
		bit            ws_ovf;
		bit            tok_ovf;
		token_result_t expected_q[$];
		int            errors;
		int            checked;
		int            lines;

		function new();
			min_args = 6'd0;
			max_args = 6'd8;
			freetext = 1'b0;
			errors = 0;
			checked = 0;
			lines = 0;
			clear_line();
		endfunction

		function void clear_line();
			started = 0;
			in_tok = 0;
			in_quote = 0;
			in_free = 0;
			take_next = 0;
			tok_cnt = 0;
			held_ws.delete();
			ws_ovf = 0;
			tok_ovf = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [5:0] val);
			case (idx)
				REG_MIN_ARGS: min_args = val;
				REG_MAX_ARGS: max_args = val;
				REG_FREETEXT: freetext = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function bit is_blank(logic [7:0] c);
			return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function void add(item_type_t t, logic [7:0] b, int idx, int argc, error_code_t e);
			token_result_t r;
			r.typ = t;
			r.tbyte = b;
			r.tindex = 7'(idx);
			r.argc = 8'(argc);
			r.valid_bit = (t == ITEM_STATUS) && (e == ERR_OK);
			r.code = e;
			r.lst = 1'b0;
			expected_q.push_back(r);
		endfunction

		function void put_content(logic [7:0] c);
			if (!tok_ovf)
				add(ITEM_TOKEN_BYTE, c, tok_cnt, 0, ERR_OK);
		endfunction

		function void close_token();
			if (!tok_ovf) begin
				add(ITEM_TOKEN_END, 8'h00, tok_cnt, 0, ERR_OK);
				tok_cnt++;
			end
			in_tok = 0;
			in_quote = 0;
			in_free = 0;
		endfunction

		// one byte into the token splitter
		function void feed(logic [7:0] c);
			if (take_next) begin
				take_next = 0;
				put_content(c);
				return;
			end
			if (!in_tok) begin
				if (c == CH_SPACE)
					return;
				if (tok_cnt >= TOKEN_CAP)
					tok_ovf = 1;
				in_tok = 1;
				if (freetext && tok_cnt == int'(max_args) && c != CH_QUOTE) begin
					in_free = 1;
					put_content(c);
				end else if (c == CH_QUOTE) begin
					in_quote = 1;
					take_next = 1;
				end else begin
					put_content(c);
				end
				return;
			end
			if (in_quote) begin
				if (c == CH_QUOTE)
					close_token();
				else
					put_content(c);
				return;
			end
			if (in_free) begin
				put_content(c);
				return;
			end
			if (c == CH_SPACE)
				close_token();
			else if (!(freetext && c == CH_QUOTE))
				put_content(c);
		endfunction

		// accepted input item: work out the results it causes
		function void note_item(logic eol, logic [7:0] c);
			int          n0;
			int          num;
			error_code_t e;
			token_result_t r;
			n0 = expected_q.size();
			if (!eol) begin
				if (is_blank(c)) begin
					if (started) begin
						if (held_ws.size() < HELD_WS_DEPTH)
							held_ws.push_back(c);
						else
							ws_ovf = 1;
					end
				end else begin
					started = 1;
					foreach (held_ws[i])
						feed(held_ws[i]);
					held_ws.delete();
					feed(c);
				end
			end else begin
				if (in_tok)
					close_token();
				num = tok_cnt - 1;
				if (ws_ovf)
					e = ERR_WS_OVF;
				else if (tok_ovf)
					e = ERR_TOKEN_OVF;
				else if (num < int'(min_args))
					e = ERR_TOO_FEW;
				else if (num > int'(max_args))
					e = ERR_TOO_MANY;
				else
					e = ERR_OK;
				add(ITEM_STATUS, 8'h00, 0, num, e);
				clear_line();
				lines++;
			end
			if (expected_q.size() > n0) begin
				r = expected_q[expected_q.size() - 1];
				r.lst = 1'b1;
				expected_q[expected_q.size() - 1] = r;
			end
		endfunction

		task report_mismatch(string field, int got, int want);
			errors++;
			if (errors <= 40)
				$display("result %0d: %s is %0d, should be %0d", checked, field, got, want);
		endtask

		task check_result(logic [1:0] typ, logic [7:0] b, logic [6:0] idx,
				logic signed [7:0] argc, logic v, logic [2:0] e, logic lst);
			token_result_t w;
			checked++;
			if (expected_q.size() == 0) begin
				report_mismatch("item_type of a result with none due", int'(typ), -1);
				return;
			end
			w = expected_q.pop_front();
			if (typ !== w.typ)
				report_mismatch("item_type", int'(typ), int'(w.typ));
			if (b !== w.tbyte)
				report_mismatch("token_byte", int'(b), int'(w.tbyte));
			if (idx !== w.tindex)
				report_mismatch("token_index", int'(idx), int'(w.tindex));
			if (argc !== w.argc)
				report_mismatch("arg_total", int'(argc), int'(w.argc));
			if (v !== w.valid_bit)
				report_mismatch("line_valid", int'(v), int'(w.valid_bit));
			if (e !== w.code)
				report_mismatch("error_code", int'(e), int'(w.code));
			if (lst !== w.lst)
				report_mismatch("last", int'(lst), int'(w.lst));
		endtask
	endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for quoted_argument_tokenizer_unit
// depends on qat_pkg, tok_sb_pkg and the tokenizer rtl
module tb_top;
	import qat_pkg::*;
	import tok_sb_pkg::*;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_EOL    = 1'b1;
	localparam int   CYCLE_LIMIT = 200000;
	localparam int   LONG_HOLD   = 300;
	localparam int   SETTLE      = 16;
	localparam int   PHASE_ITEMS = 8;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [5:0]        cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic              kind;
	logic [7:0]        data_byte;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        item_type;
	logic [7:0]        token_byte;
	logic [6:0]        token_index;
	logic signed [7:0] arg_total;
	logic              line_valid;
	logic [2:0]        error_code;
	logic              last;

	token_scoreboard sb;
	logic [7:0]      line_q[$];
	int              cycle_count = 0;
	int              items_sent = 0;
	int              settings_used = 0;
	int              burst_left = 0;
	bit              gaps_on = 1;
	// long receiver hold-offs asked by the stimulus and served by the receiver
	int              holds_asked = 0;
	int              holds_done = 0;

	quoted_argument_tokenizer_unit #(
		.PENDING_DEPTH(HELD_WS_DEPTH),
		.TOKEN_LIMIT  (TOKEN_CAP)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.item_type  (item_type),
		.token_byte (token_byte),
		.token_index(token_index),
		.arg_total  (arg_total),
		.line_valid (line_valid),
		.error_code (error_code),
		.last       (last)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count, sb.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// outputs are stable at the falling edge, so a handshake seen here is taken at the next rise
	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result(item_type, token_byte, token_index, arg_total, line_valid,
				error_code, last);
	end

	// receiver: stall pattern drawn at random among four modes; a long hold-off when one is asked
	initial begin : receiver
		int rx_cycle;
		int rx_mode;
		out_ready = 1'b0;
		rx_cycle = 0;
		rx_mode = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			if (holds_done < holds_asked) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (rx_cycle % 4) != 3;
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// one item on the input channel; returns at the edge that takes it, valid still high
	task automatic send_item(input logic k, input logic [7:0] b);
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		do
			@(negedge clk);
		while (in_ready !== 1'b1);
		sb.note_item(k, b);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(KIND_BYTE, s[i]);
		send_item(KIND_EOL, 8'($urandom));
	endtask

	// sender stops until every due result is in, then lets the pipeline settle
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// all three registers, back to back; upper bits of the freetext write are don't-care
	task automatic write_cfg(input logic [5:0] mn, input logic [5:0] mx, input logic ft);
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_ARGS;
		cfg_wdata <= mn;
		@(posedge clk);
		cfg_index <= REG_MAX_ARGS;
		cfg_wdata <= mx;
		@(posedge clk);
		cfg_index <= REG_FREETEXT;
		cfg_wdata <= {5'($urandom), ft};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(REG_MIN_ARGS, mn);
		sb.set_reg(REG_MAX_ARGS, mx);
		sb.set_reg(REG_FREETEXT, {5'd0, ft});
		settings_used++;
	endtask

	// token content: mostly letters, now and then quotes, control and high bytes
	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4, 5, 6, 7: return 8'($urandom_range(8'h61, 8'h7A));
			8: return 8'($urandom_range(8'h30, 8'h39));
			9, 10: return 8'($urandom_range(8'h21, 8'h7E));
			11: return 8'($urandom_range(8'h80, 8'hFF));
			12: return CH_QUOTE;
			13: return 8'($urandom_range(8'h00, 8'h08));
			default: return 8'($urandom_range(8'h0E, 8'h1F));
		endcase
	endfunction

	function automatic logic [7:0] ws_char();
		if ($urandom_range(0, 3) != 0)
			return CH_SPACE;
		return 8'($urandom_range(CH_TAB, CH_CR));
	endfunction

	// a command line: mostly well formed, some unterminated quotes, some plain noise
	function automatic void build_line();
		int n_tok;
		int len;
		line_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			len = $urandom_range(1, 10);
			repeat (len) line_q.push_back(8'($urandom));
			return;
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) line_q.push_back(ws_char());
		n_tok = $urandom_range(0, 7);
		for (int t = 0; t < n_tok; t++) begin
			if (t > 0)
				repeat ($urandom_range(1, 3)) line_q.push_back(ws_char());
			if ($urandom_range(0, 3) == 0) begin
				line_q.push_back(CH_QUOTE);
				len = $urandom_range(0, 5);
				repeat (len) line_q.push_back(($urandom_range(0, 3) == 0) ? ws_char() : word_char());
				if ($urandom_range(0, 4) != 0)
					line_q.push_back(CH_QUOTE);
			end else begin
				len = $urandom_range(1, 5);
				repeat (len) line_q.push_back(word_char());
			end
		end
		repeat ($urandom_range(0, 2)) line_q.push_back(ws_char());
	endfunction

	initial begin : stimulus
		bit paused;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MIN_ARGS;
		cfg_wdata = 6'd0;
		in_valid = 1'b0;
		kind = KIND_BYTE;
		data_byte = 8'h00;
		paused = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: leading and trailing whitespace dropped
		send_text("  ab\t");
		// quote as the last byte leaves an empty token open
		send_text("c \"");
		// empty line, no tokens at all
		send_item(KIND_EOL, 8'hFF);
		// byte extremes, a held cr released into a token, a quoted token open at end of line
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_BYTE, CH_CR);
		send_item(KIND_BYTE, 8'h80);
		send_item(KIND_BYTE, CH_SPACE);
		send_text("\"q r");

		// minimum above maximum, freetext from the second token, stray quote dropped
		wait_drain();
		write_cfg(6'd2, 6'd1, 1'b1);
		send_text("ab\"c d\"e f");

		// whitespace store: filled with tabs and spaces, one byte too many, then released
		wait_drain();
		write_cfg(6'd0, 6'd63, 1'b0);
		send_item(KIND_BYTE, 8'h78);
		repeat (HELD_WS_DEPTH / 2) send_item(KIND_BYTE, CH_TAB);
		repeat (HELD_WS_DEPTH / 2 + 1) send_item(KIND_BYTE, CH_SPACE);
		send_text("y");

		// token count runs past its limit, parsing goes on silently;
		// streamed with no gaps against a long receiver hold-off
		gaps_on = 0;
		holds_asked++;
		for (int t = 0; t < TOKEN_CAP + 1; t++) begin
			send_item(KIND_BYTE, 8'($urandom_range(8'h61, 8'h7A)));
			send_item(KIND_BYTE, CH_SPACE);
		end
		send_text("\"z");
		gaps_on = 1;

		// random phases, each with its own settings
		for (int ph = 0; ph < 3; ph++) begin
			int phase_start;
			wait_drain();
			case (ph)
				0: write_cfg(6'd63, 6'd0, 1'b1);
				1: write_cfg(6'd1, 6'd3, 1'b1);
				default: write_cfg(6'($urandom_range(0, 4)), 6'($urandom_range(0, 6)),
					1'($urandom_range(0, 1)));
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				build_line();
				for (int i = 0; i < line_q.size(); i++) begin
					send_item(KIND_BYTE, line_q[i]);
					// mid-line pause until everything due has come out
					if (ph == 1 && !paused && i == 2) begin
						paused = 1;
						wait_drain();
					end
				end
				send_item(KIND_EOL, 8'($urandom));
			end
		end

		wait_drain();
		$display("covered %0d items in %0d lines over %0d register settings",
			items_sent, sb.lines, settings_used);
		$display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### quoted_argument_tokenizer_unit.f
hdl/qat_pkg.sv
hdl/qat_ram.sv
hdl/qat_fifo.sv
hdl/qat_front.sv
hdl/qat_back.sv
hdl/quoted_argument_tokenizer_unit.sv
verif/tok_sb_pkg.sv
verif/tb_top.sv
